// File: rtl/ternary_packed_row_dot_defines.svh
// ----------------------------------------------------------------------------
// ternary_packed_row_dot assertion macros
// shared concurrent assertion forms for the ternary row dot product block
// ----------------------------------------------------------------------------
`ifndef TERNARY_PACKED_ROW_DOT_DEFINES_SVH
`define TERNARY_PACKED_ROW_DOT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TPR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpr check failed");

// next-cycle implication, checked outside reset
`define TPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpr check failed");

`endif

// File: rtl/tpr_pkg.sv
// ----------------------------------------------------------------------------
// tpr_pkg
// types and constants of the ternary packed row dot product block
// ----------------------------------------------------------------------------
`default_nettype none

package tpr_pkg;

   localparam int LANES     = 4;
   localparam int ACT_WIDTH = 16;
   localparam int MAX_ROWS  = 4096;
   localparam int ACC_W     = 32;
   localparam int ROW_W     = 12;
   localparam int ROW_NEXT_W = 17;
   localparam int LANE_W    = ACT_WIDTH + 1;
   localparam int DELTA_W   = ACT_WIDTH + 3;
   localparam int CODE_W    = 2;

   localparam int FIFO_DEPTH = 3;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 2;
   localparam int OCC_W      = 3;

   localparam logic [CODE_W-1:0] CODE_PLUS  = 2'b01;
   localparam logic [CODE_W-1:0] CODE_MINUS = 2'b10;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef logic signed [ACT_WIDTH-1:0] act_type;
   typedef logic signed [LANE_W-1:0]    lane_sum_type;

   typedef struct packed {
      logic [7:0] packed_weights;
      act_type    act_lane0;
      act_type    act_lane1;
      act_type    act_lane2;
      act_type    act_lane3;
      logic [2:0] lanes_valid;
      logic       row_end;
      logic       matrix_end;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] row_sum;
      logic [ROW_W-1:0]        row_number;
      logic                    sum_clipped;
      logic                    last_row;
   } rsp_type;

   // accumulator side, seen by the flow control
   typedef struct packed {
      logic result_pending;
   } acc_status_type;

   // result queue side, seen by the flow control
   typedef struct packed {
      logic [CNT_W-1:0] count;
   } fifo_status_type;

endpackage

`default_nettype wire

// File: rtl/tpr_lane.sv
// ----------------------------------------------------------------------------
// tpr_lane
// one ternary lane: decodes a 2-bit weight code and signs the activation
// ----------------------------------------------------------------------------
`default_nettype none

module tpr_lane (
   input  wire logic [tpr_pkg::CODE_W-1:0] code,
   input  wire tpr_pkg::act_type           act,
   input  wire logic                       lane_on,
   output tpr_pkg::lane_sum_type           contrib
);

   tpr_pkg::lane_sum_type act_ext;

   assign act_ext = {act[tpr_pkg::ACT_WIDTH-1], act};

   always_comb begin
      contrib = '0;
      if (lane_on) begin
         case (code)
            tpr_pkg::CODE_PLUS:  contrib = act_ext;
            tpr_pkg::CODE_MINUS: contrib = -act_ext;
            default:             contrib = '0;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/tpr_accum.sv
// ----------------------------------------------------------------------------
// tpr_accum
// merges the lane contributions and keeps the saturating row accumulator
// ----------------------------------------------------------------------------
`default_nettype none
`include "ternary_packed_row_dot_defines.svh"

module tpr_accum (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire tpr_pkg::lane_sum_type lane_sum [tpr_pkg::LANES],
   input  wire logic                  row_end,
   input  wire logic                  matrix_end,
   output tpr_pkg::acc_status_type    status,
   output logic                       push,
   output tpr_pkg::rsp_type           push_data
);

   // merge stage
   logic                                s1_valid_ff, s1_valid_in;
   logic                                s1_row_end_ff, s1_matrix_end_ff;
   logic signed [tpr_pkg::DELTA_W-1:0]  delta_ff, delta_in;

   // accumulate stage
   logic signed [tpr_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic                                clip_ff, clip_in;
   logic [tpr_pkg::ROW_W-1:0]           row_count_ff, row_count_in;

   logic signed [tpr_pkg::ACC_W:0]      total;
   logic signed [tpr_pkg::ACC_W-1:0]    sat_sum;
   logic                                clip_now;
   logic [tpr_pkg::ROW_NEXT_W-1:0]      row_next;

   always_comb begin
      delta_in = '0;
      for (int i = 0; i < tpr_pkg::LANES; i++) begin
         delta_in = delta_in + tpr_pkg::DELTA_W'($signed(lane_sum[i]));
      end
      s1_valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (in_valid) begin
         delta_ff         <= delta_in;
         s1_row_end_ff    <= row_end;
         s1_matrix_end_ff <= matrix_end;
      end
   end

   // one saturation per byte
   always_comb begin
      total = {acc_ff[tpr_pkg::ACC_W-1], acc_ff}
            + {{(tpr_pkg::ACC_W + 1 - tpr_pkg::DELTA_W){delta_ff[tpr_pkg::DELTA_W-1]}},
               delta_ff};
      clip_now = total[tpr_pkg::ACC_W] != total[tpr_pkg::ACC_W-1];
      if (clip_now) begin
         sat_sum = total[tpr_pkg::ACC_W] ? tpr_pkg::ACC_MIN : tpr_pkg::ACC_MAX;
      end else begin
         sat_sum = total[tpr_pkg::ACC_W-1:0];
      end
   end

   always_comb begin
      row_next              = tpr_pkg::ROW_NEXT_W'(row_count_ff) + 1'b1;
      acc_in                = acc_ff;
      clip_in               = clip_ff;
      row_count_in          = row_count_ff;
      push                  = 1'b0;
      push_data.row_sum     = sat_sum;
      push_data.row_number  = row_count_ff;
      push_data.sum_clipped = clip_ff | clip_now;
      push_data.last_row    = s1_matrix_end_ff;
      if (s1_valid_ff) begin
         if (s1_row_end_ff) begin
            push    = 1'b1;
            acc_in  = '0;
            clip_in = 1'b0;
            if (s1_matrix_end_ff ||
                row_next >= tpr_pkg::ROW_NEXT_W'(tpr_pkg::MAX_ROWS)) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_next[tpr_pkg::ROW_W-1:0];
            end
         end else begin
            acc_in  = sat_sum;
            clip_in = clip_ff | clip_now;
         end
      end
      status.result_pending = s1_valid_ff & s1_row_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         row_count_ff <= '0;
      end else begin
         acc_ff       <= acc_in;
         clip_ff      <= clip_in;
         row_count_ff <= row_count_in;
      end
   end

   // a closed row leaves a clean accumulator for the next one
   `TPR_ASSERT_NEXT(a_acc_cleared, clock, reset, push, acc_ff == '0)
   `TPR_ASSERT_NEXT(a_clip_cleared, clock, reset, push, !clip_ff)

endmodule

`default_nettype wire

// File: rtl/tpr_out_fifo.sv
// ----------------------------------------------------------------------------
// tpr_out_fifo
// small result queue that decouples the accumulator from the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module tpr_out_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire tpr_pkg::rsp_type    push_data,
   input  wire logic                pop,
   output tpr_pkg::fifo_status_type status,
   output logic                     out_valid,
   output tpr_pkg::rsp_type         out_data
);

   tpr_pkg::rsp_type              entry_ff [tpr_pkg::FIFO_DEPTH];
   logic [tpr_pkg::PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tpr_pkg::PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tpr_pkg::CNT_W-1:0]     count_ff, count_in;

   function automatic logic [tpr_pkg::PTR_W-1:0] ptr_step(
      input logic [tpr_pkg::PTR_W-1:0] ptr
   );
      if (ptr == tpr_pkg::PTR_W'(tpr_pkg::FIFO_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid    = count_ff != '0;
   assign out_data     = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;

endmodule

`default_nettype wire

// File: rtl/ternary_packed_row_dot.sv
// ----------------------------------------------------------------------------
// ternary_packed_row_dot
// streaming ternary row dot product over packed 2-bit weights
// ----------------------------------------------------------------------------
// Takes one weight byte per cycle with its four Q1.15 activations and accepts
// a new beat every cycle while req_stall is low. Four lanes decode the codes
// in parallel and a merge stage sums them into a byte delta; the next stage
// adds that delta to the 32-bit saturating row accumulator, a feedback loop
// through one register that sets the rate. A row result passes the merge
// register and the accumulate stage and is written into a three-entry result
// queue, and rsp_valid then rises; it is taken at an edge with rsp_stall low.
// req_stall rises only when the queue plus a result still in flight would
// fill it, so the input keeps flowing while up to two finished results wait.
`default_nettype none
`include "ternary_packed_row_dot_defines.svh"

module ternary_packed_row_dot (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tpr_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tpr_pkg::rsp_type      rsp_payload
);

   tpr_pkg::act_type         act [tpr_pkg::LANES];
   tpr_pkg::lane_sum_type    lane_sum [tpr_pkg::LANES];
   tpr_pkg::acc_status_type  acc_status;
   tpr_pkg::fifo_status_type fifo_status;
   tpr_pkg::rsp_type         push_data;
   logic                     push;
   logic                     pop;
   logic                     accept;
   logic [tpr_pkg::OCC_W-1:0] occupancy;

   assign act[0] = req_payload.act_lane0;
   assign act[1] = req_payload.act_lane1;
   assign act[2] = req_payload.act_lane2;
   assign act[3] = req_payload.act_lane3;

   // queued results plus the one that may land next cycle
   assign occupancy = tpr_pkg::OCC_W'(fifo_status.count)
                    + tpr_pkg::OCC_W'(acc_status.result_pending);
   assign req_stall = occupancy >= tpr_pkg::OCC_W'(tpr_pkg::FIFO_DEPTH);
   assign accept    = req_valid & ~req_stall;
   assign pop       = rsp_valid & ~rsp_stall;

   for (genvar i = 0; i < tpr_pkg::LANES; i++) begin : g_lane
      tpr_lane u_lane (
         .code    (req_payload.packed_weights[2*i +: tpr_pkg::CODE_W]),
         .act     (act[i]),
         .lane_on (req_payload.lanes_valid > 3'(i)),
         .contrib (lane_sum[i])
      );
   end

   tpr_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .lane_sum   (lane_sum),
      .row_end    (req_payload.row_end),
      .matrix_end (req_payload.matrix_end),
      .status     (acc_status),
      .push       (push),
      .push_data  (push_data)
   );

   tpr_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .status    (fifo_status),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload)
   );

   // the credit check must keep the queue from ever overflowing
   `TPR_ASSERT_NOW(a_no_overflow, clock, reset, push && !pop,
      fifo_status.count < tpr_pkg::CNT_W'(tpr_pkg::FIFO_DEPTH))
   `TPR_ASSERT_NOW(a_credit_bound, clock, reset, 1'b1,
      occupancy <= tpr_pkg::OCC_W'(tpr_pkg::FIFO_DEPTH))

endmodule

`default_nettype wire
